FILE: sv/fixed_point_alu_macros.svh
// assertion macros used by the checker of the fixed-point alu
// no dependencies
`ifndef FIXED_POINT_ALU_MACROS_SVH
`define FIXED_POINT_ALU_MACROS_SVH

// property checked at every clock edge outside reset
`define FPA_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every clock edge, reset included
`define FPA_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/fpa_pkg.sv
// shared types of the fixed-point alu
// no dependencies
package fpa_pkg;

   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_LT       = 4'd4,
      OP_GT       = 4'd5,
      OP_LE       = 4'd6,
      OP_GE       = 4'd7,
      OP_EQ       = 4'd8,
      OP_NE       = 4'd9,
      OP_MIN      = 4'd10,
      OP_MAX      = 4'd11,
      OP_INC      = 4'd12,
      OP_DEC      = 4'd13,
      OP_TO_INT   = 4'd14,
      OP_FROM_INT = 4'd15
   } op_type;

endpackage

FILE: sv/fpa_if.sv
// request and response channel interfaces of the fixed-point alu
// depends on fpa_pkg
interface fpa_req_if #(parameter int WORD_BITS = 32);
   logic                        valid;
   logic                        ready;
   fpa_pkg::op_type             operation;
   logic signed [WORD_BITS-1:0] operand_a;
   logic signed [WORD_BITS-1:0] operand_b;

   modport source (output valid, operation, operand_a, operand_b, input ready);
   modport sink (input valid, operation, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if #(parameter int WORD_BITS = 32);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] result_value;
   logic                        compare_true;
   logic                        saturated;
   logic                        divide_by_zero;

   modport source (output valid, result_value, compare_true, saturated, divide_by_zero,
                   input ready);
   modport sink (input valid, result_value, compare_true, saturated, divide_by_zero,
                 output ready);
endinterface

FILE: sv/fixed_point_alu.sv
// fixed-point alu, Q24.8 with the default parameters
// throughput one transaction per cycle while the output is not stalled, set by the one-bit-per-stage divider pipeline
// every operation goes through the same pipeline so results leave in order
// whole pipeline advances when the output register is empty or being taken
// synchronous active-high reset clears the valid bits only
module fixed_point_alu #(
   parameter int FRACTION_BITS = 8,
   parameter int WORD_BITS     = 32
) (
   input logic         clock,
   input logic         reset,
   fpa_req_if.sink     req_ch,
   fpa_rsp_if.source   rsp_ch
);
   import fpa_pkg::*;

   localparam int W    = WORD_BITS;
   localparam int F    = FRACTION_BITS;
   localparam int QW   = W + F;
   localparam int PW   = (2 * W + 1 > QW + 1) ? 2 * W + 1 : QW + 1;
   localparam int TAGW = W + 5;
   localparam logic [W-1:0]    MAXWORD = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]    MINWORD = {1'b1, {(W-1){1'b0}}};
   localparam logic [PW-1:0]   MAXP    = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic [2*W:0]    HALF    = (F > 0) ? ((2*W+1)'(1) << (F > 0 ? F - 1 : 0)) : '0;

   // sign and magnitude back to a word, clamped
   function automatic logic [W:0] pack_fn(input logic neg, input logic [PW-1:0] mag);
      logic sat;
      logic [W-1:0] val;
      sat = neg ? (mag > MAXP + PW'(1)) : (mag > MAXP);
      if (sat) val = neg ? MINWORD : MAXWORD;
      else     val = neg ? (~mag[W-1:0] + W'(1)) : mag[W-1:0];
      return {sat, val};
   endfunction

   // clamp a one-bit-wider sum
   function automatic logic [W:0] addsat_fn(input logic [W:0] s);
      logic sat;
      sat = (s[W] != s[W-1]);
      return {sat, sat ? (s[W] ? MINWORD : MAXWORD) : s[W-1:0]};
   endfunction

   logic en;
   assign en           = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = en;

   // stage 1: input register
   logic                v1_ff;
   op_type              op1_ff;
   logic signed [W-1:0] a1_ff, b1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_ch.valid;
      end
      if (en) begin
         op1_ff <= req_ch.operation;
         a1_ff  <= req_ch.operand_a;
         b1_ff  <= req_ch.operand_b;
      end
   end

   // stage 2: magnitudes, product and the simple operations
   logic [W-1:0]   maga_in, magb_in;
   logic [2*W-1:0] prod_in;
   logic [W-1:0]   sres_in;
   logic           scmp_in, ssat_in;
   logic [W:0]     tmp;

   always_comb begin
      maga_in = a1_ff[W-1] ? (~a1_ff + W'(1)) : a1_ff;
      magb_in = b1_ff[W-1] ? (~b1_ff + W'(1)) : b1_ff;
      prod_in = {{W{1'b0}}, maga_in} * {{W{1'b0}}, magb_in};
      sres_in = '0;
      scmp_in = 1'b0;
      ssat_in = 1'b0;
      tmp     = '0;
      case (op1_ff)
         OP_ADD: tmp = {a1_ff[W-1], a1_ff} + {b1_ff[W-1], b1_ff};
         OP_SUB: tmp = {a1_ff[W-1], a1_ff} - {b1_ff[W-1], b1_ff};
         OP_INC: tmp = {a1_ff[W-1], a1_ff} + (W+1)'(1);
         OP_DEC: tmp = {a1_ff[W-1], a1_ff} - (W+1)'(1);
         default: tmp = '0;
      endcase
      case (op1_ff)
         OP_ADD, OP_SUB, OP_INC, OP_DEC: {ssat_in, sres_in} = addsat_fn(tmp);
         OP_LT:     scmp_in = (a1_ff < b1_ff);
         OP_GT:     scmp_in = (a1_ff > b1_ff);
         OP_LE:     scmp_in = (a1_ff <= b1_ff);
         OP_GE:     scmp_in = (a1_ff >= b1_ff);
         OP_EQ:     scmp_in = (a1_ff == b1_ff);
         OP_NE:     scmp_in = (a1_ff != b1_ff);
         OP_MIN:    sres_in = (a1_ff < b1_ff) ? a1_ff : b1_ff;
         OP_MAX:    sres_in = (a1_ff > b1_ff) ? a1_ff : b1_ff;
         OP_TO_INT: sres_in = a1_ff >>> F;
         default:   sres_in = '0;
      endcase
   end

   logic           v2_ff, sa2_ff, neg2_ff, scmp2_ff, ssat2_ff;
   op_type         op2_ff;
   logic [W-1:0]   maga2_ff, magb2_ff, sres2_ff;
   logic [2*W-1:0] prod2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         op2_ff   <= op1_ff;
         sa2_ff   <= a1_ff[W-1];
         neg2_ff  <= a1_ff[W-1] ^ b1_ff[W-1];
         maga2_ff <= maga_in;
         magb2_ff <= magb_in;
         prod2_ff <= prod_in;
         sres2_ff <= sres_in;
         scmp2_ff <= scmp_in;
         ssat2_ff <= ssat_in;
      end
   end

   // stage 3: round and clamp the product, scale for from_int
   logic [2*W:0] rnd;
   logic [W:0]   fpk_in;

   always_comb begin
      rnd = ({1'b0, prod2_ff} + HALF) >> F;
      case (op2_ff)
         OP_MUL:      fpk_in = pack_fn(neg2_ff, PW'(rnd));
         OP_FROM_INT: fpk_in = pack_fn(sa2_ff, PW'(maga2_ff) << F);
         default:     fpk_in = {ssat2_ff, sres2_ff};
      endcase
   end

   logic            v3_ff;
   logic [TAGW-1:0] tag3_ff;
   logic [QW-1:0]   dvd3_ff;
   logic [W-1:0]    dvs3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         tag3_ff <= {(op2_ff == OP_DIV), sa2_ff, neg2_ff, scmp2_ff, fpk_in};
         dvd3_ff <= QW'(maga2_ff) << F;
         dvs3_ff <= magb2_ff;
      end
   end

   // divider stages
   logic            dv_valid;
   logic [QW-1:0]   dv_quot;
   logic [W-1:0]    dv_rem, dv_dvs;
   logic [TAGW-1:0] dv_tag;

   fpa_div #(.W(W), .F(F), .TAGW(TAGW)) u_div (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (v3_ff),
      .in_dividend (dvd3_ff),
      .in_divisor  (dvs3_ff),
      .in_tag      (tag3_ff),
      .out_valid   (dv_valid),
      .out_quot    (dv_quot),
      .out_rem     (dv_rem),
      .out_divisor (dv_dvs),
      .out_tag     (dv_tag)
   );

   // output stage: round the quotient, pick the result
   logic            is_div, t_sa, t_neg, t_cmp;
   logic [W:0]      t_pk, dpk;
   logic            rup;
   logic [QW:0]     qr;
   logic [W-1:0]    res_in;
   logic            cmp_in, sat_in, dz_in;

   always_comb begin
      {is_div, t_sa, t_neg, t_cmp, t_pk} = dv_tag;
      rup    = ({dv_rem, 1'b0} >= {1'b0, dv_dvs});
      qr     = {1'b0, dv_quot} + (QW+1)'(rup);
      dpk    = pack_fn(t_neg, PW'(qr));
      res_in = t_pk[W-1:0];
      sat_in = t_pk[W];
      cmp_in = t_cmp;
      dz_in  = 1'b0;
      if (is_div) begin
         cmp_in = 1'b0;
         if (dv_dvs == '0) begin
            dz_in  = 1'b1;
            sat_in = 1'b0;
            res_in = t_sa ? MINWORD : MAXWORD;
         end else begin
            sat_in = dpk[W];
            res_in = dpk[W-1:0];
         end
      end
   end

   logic         rv_ff, rcmp_ff, rsat_ff, rdz_ff;
   logic [W-1:0] rres_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (en) begin
         rv_ff <= dv_valid;
      end
      if (en) begin
         rres_ff <= res_in;
         rcmp_ff <= cmp_in;
         rsat_ff <= sat_in;
         rdz_ff  <= dz_in;
      end
   end

   assign rsp_ch.valid          = rv_ff;
   assign rsp_ch.result_value   = rres_ff;
   assign rsp_ch.compare_true   = rcmp_ff;
   assign rsp_ch.saturated      = rsat_ff;
   assign rsp_ch.divide_by_zero = rdz_ff;
endmodule

FILE: sv/fpa_div.sv
// pipelined restoring divider, one quotient bit per stage, with a tag carried along
// no package dependencies
module fpa_div #(
   parameter int W    = 32,
   parameter int F    = 8,
   parameter int TAGW = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [W+F-1:0]  in_dividend,
   input  logic [W-1:0]    in_divisor,
   input  logic [TAGW-1:0] in_tag,
   output logic            out_valid,
   output logic [W+F-1:0]  out_quot,
   output logic [W-1:0]    out_rem,
   output logic [W-1:0]    out_divisor,
   output logic [TAGW-1:0] out_tag
);
   localparam int QW     = W + F;
   localparam int STAGES = QW;

   logic            vld_ff [STAGES];
   logic [W-1:0]    rem_ff [STAGES];
   logic [QW-1:0]   wrk_ff [STAGES];
   logic [W-1:0]    dvs_ff [STAGES];
   logic [TAGW-1:0] tag_ff [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic            p_vld;
      logic [W-1:0]    p_rem;
      logic [QW-1:0]   p_wrk;
      logic [W-1:0]    p_dvs;
      logic [TAGW-1:0] p_tag;
      logic [W:0]      trial;
      logic [W:0]      diff;
      logic            ge;
      logic [W-1:0]    rem_in;
      logic [QW-1:0]   wrk_in;

      if (k == 0) begin : g_first
         assign p_vld = in_valid;
         assign p_rem = '0;
         assign p_wrk = in_dividend;
         assign p_dvs = in_divisor;
         assign p_tag = in_tag;
      end else begin : g_next
         assign p_vld = vld_ff[k-1];
         assign p_rem = rem_ff[k-1];
         assign p_wrk = wrk_ff[k-1];
         assign p_dvs = dvs_ff[k-1];
         assign p_tag = tag_ff[k-1];
      end

      // shift in the next dividend bit, quotient bits fill from the bottom
      always_comb begin
         trial  = {p_rem, p_wrk[QW-1]};
         diff   = trial - {1'b0, p_dvs};
         ge     = (trial >= {1'b0, p_dvs});
         rem_in = ge ? diff[W-1:0] : trial[W-1:0];
         wrk_in = {p_wrk[QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= p_vld;
         end
         if (en) begin
            rem_ff[k] <= rem_in;
            wrk_ff[k] <= wrk_in;
            dvs_ff[k] <= p_dvs;
            tag_ff[k] <= p_tag;
         end
      end
   end

   assign out_valid   = vld_ff[STAGES-1];
   assign out_quot    = wrk_ff[STAGES-1];
   assign out_rem     = rem_ff[STAGES-1];
   assign out_divisor = dvs_ff[STAGES-1];
   assign out_tag     = tag_ff[STAGES-1];
endmodule

FILE: sv/fpa_checker.sv
// port-level checks of the fixed-point alu, bound to the top level
// depends on fixed_point_alu_macros.svh
`include "fixed_point_alu_macros.svh"

module fpa_checker #(
   parameter int WORD_BITS = 32
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [WORD_BITS-1:0] rsp_result_value,
   input logic                 rsp_compare_true,
   input logic                 rsp_saturated,
   input logic                 rsp_divide_by_zero
);
   localparam logic [WORD_BITS-1:0] MAXWORD = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] MINWORD = {1'b1, {(WORD_BITS-1){1'b0}}};

   // comparisons give a zero word and no flags
   `FPA_ASSERT(a_cmp_clean, clock, reset, rsp_valid && rsp_compare_true |-> rsp_result_value == '0 && !rsp_saturated && !rsp_divide_by_zero, "comparison transaction carries a result or flag")

   // a clamped or zero-divisor result sits on a word limit
   `FPA_ASSERT(a_clamp_limit, clock, reset, rsp_valid && (rsp_saturated || rsp_divide_by_zero) |-> rsp_result_value == MAXWORD || rsp_result_value == MINWORD, "clamped result is not a word limit")

   `FPA_ASSERT(a_flag_excl, clock, reset, rsp_valid |-> !(rsp_saturated && rsp_divide_by_zero), "saturated and divide_by_zero both set")

   `FPA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value), "stalled response changed")

   `FPA_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_valid, "response valid right after reset")
endmodule

bind fixed_point_alu fpa_checker #(.WORD_BITS(WORD_BITS)) u_fpa_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_result_value   (rsp_ch.result_value),
   .rsp_compare_true   (rsp_ch.compare_true),
   .rsp_saturated      (rsp_ch.saturated),
   .rsp_divide_by_zero (rsp_ch.divide_by_zero)
);

FILE: tb/testbench.sv
// self-checking testbench of the fixed-point alu: directed table, then random transactions
// depends on fpa_pkg, fpa_if and fixed_point_alu
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import fpa_pkg::*;

   localparam int FRAC = 8;
   localparam int LATENCY = 44;
   localparam int RANDOM_COUNT = 1750;
   localparam logic signed [31:0] WORD_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] WORD_MIN = 32'sh80000000;

   typedef struct packed {
      logic signed [31:0] value;
      logic               cmp;
      logic               sat;
      logic               dz;
   } alu_result_type;

   typedef struct {
      op_type             op;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic               typed;
      alu_result_type     res;
   } vector_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fpa_req_if #(.WORD_BITS(32)) req_ch ();
   fpa_rsp_if #(.WORD_BITS(32)) rsp_ch ();

   fixed_point_alu #(.FRACTION_BITS(FRAC), .WORD_BITS(32)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #6 clock = ~clock;

   alu_result_type pending_results[$];
   int             mismatch_count = 0;
   bit             no_gaps = 1'b0;

   // clamp an exact wide value to the word range
   function automatic alu_result_type clamp_word(logic signed [95:0] v);
      alu_result_type r;
      r = '0;
      if (v > 96'(WORD_MAX)) begin
         r.value = WORD_MAX;
         r.sat = 1'b1;
      end else if (v < 96'(WORD_MIN)) begin
         r.value = WORD_MIN;
         r.sat = 1'b1;
      end else begin
         r.value = v[31:0];
      end
      return r;
   endfunction

   function automatic alu_result_type alu_predict(op_type op, logic signed [31:0] a,
                                                  logic signed [31:0] b);
      alu_result_type     r;
      logic signed [95:0] wa, wb;
      logic        [95:0] mag, den, quo, rem;
      logic               neg;
      r = '0;
      wa = 96'(a);
      wb = 96'(b);
      neg = a[31] ^ b[31];
      case (op)
         OP_ADD: r = clamp_word(wa + wb);
         OP_SUB: r = clamp_word(wa - wb);
         OP_INC: r = clamp_word(wa + 96'sd1);
         OP_DEC: r = clamp_word(wa - 96'sd1);
         OP_MUL: begin
            mag = ((wa < 0 ? -wa : wa) * (wb < 0 ? -wb : wb) + (96'd1 << (FRAC - 1))) >> FRAC;
            r = clamp_word(neg ? -$signed(mag) : $signed(mag));
         end
         OP_DIV: begin
            if (b == 0) begin
               r.value = a[31] ? WORD_MIN : WORD_MAX;
               r.dz = 1'b1;
            end else begin
               den = wb < 0 ? -wb : wb;
               mag = (wa < 0 ? -wa : wa) << FRAC;
               quo = mag / den;
               rem = mag % den;
               // round half away from zero
               if (rem >= den - rem) quo = quo + 1;
               r = clamp_word(neg ? -$signed(quo) : $signed(quo));
            end
         end
         OP_LT: r.cmp = a < b;
         OP_GT: r.cmp = a > b;
         OP_LE: r.cmp = a <= b;
         OP_GE: r.cmp = a >= b;
         OP_EQ: r.cmp = a == b;
         OP_NE: r.cmp = a != b;
         OP_MIN: r.value = a < b ? a : b;
         OP_MAX: r.value = a > b ? a : b;
         OP_TO_INT: r.value = a >>> FRAC;
         default: r = clamp_word(wa <<< FRAC);
      endcase
      return r;
   endfunction

   // valid stays high from one transaction to the next unless an idle cycle comes between
   task automatic send_operation(op_type op, logic signed [31:0] a, logic signed [31:0] b);
      while (!no_gaps && $urandom_range(99) < 36) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.operation <= op;
      req_ch.operand_a <= a;
      req_ch.operand_b <= b;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic logic signed [31:0] random_operand();
      case ($urandom_range(5))
         0: return $urandom_range(1) ? WORD_MAX - $urandom_range(3) : WORD_MIN + $urandom_range(3);
         1: return $signed($urandom_range(2047)) - 1024;
         2: return $signed($urandom_range(1 << 20)) - (1 << 19);
         3: return $signed($urandom_range(3)) - 1;
         default: return $urandom();
      endcase
   endfunction

   // a directed row carries its result only where it is obvious
   function automatic vector_type row(op_type op, logic signed [31:0] a, logic signed [31:0] b,
                                      logic typed = 1'b0, logic signed [31:0] value = 0,
                                      logic cmp = 0, logic sat = 0, logic dz = 0);
      vector_type v;
      v.op = op;
      v.a = a;
      v.b = b;
      v.typed = typed;
      v.res = '{value, cmp, sat, dz};
      return v;
   endfunction

   vector_type directed[$];

   // predictions are pushed at acceptance
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         pending_results.push_back(alu_predict(req_ch.operation, req_ch.operand_a,
                                               req_ch.operand_b));
   end

   always @(posedge clock) begin
      alu_result_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.result_value, rsp_ch.compare_true, rsp_ch.saturated,
                 rsp_ch.divide_by_zero};
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected transaction %p", got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= no_gaps || $urandom_range(99) >= 36;
   end

   initial begin
      #20ms;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      alu_result_type want;
      int             wait_cycles;
      req_ch.valid = 1'b0;
      req_ch.operation = OP_ADD;
      req_ch.operand_a = 0;
      req_ch.operand_b = 0;
      rsp_ch.ready = 1'b0;
      directed.push_back(row(OP_ADD, WORD_MAX, 1, 1, WORD_MAX, 0, 1));
      directed.push_back(row(OP_SUB, WORD_MIN, 1, 1, WORD_MIN, 0, 1));
      directed.push_back(row(OP_MUL, 32'sh100, 32'sh100, 1, 32'sh100));
      directed.push_back(row(OP_MUL, WORD_MIN, WORD_MIN, 1, WORD_MAX, 0, 1));
      directed.push_back(row(OP_MUL, -1, 128));
      directed.push_back(row(OP_MUL, 1, 128));
      directed.push_back(row(OP_DIV, 0, 0, 1, WORD_MAX, 0, 0, 1));
      directed.push_back(row(OP_DIV, -5, 0, 1, WORD_MIN, 0, 0, 1));
      directed.push_back(row(OP_DIV, WORD_MAX, 1, 1, WORD_MAX, 0, 1));
      directed.push_back(row(OP_DIV, WORD_MIN, -1));
      directed.push_back(row(OP_DIV, 1, 512));
      directed.push_back(row(OP_DIV, -1, 3));
      directed.push_back(row(OP_LT, WORD_MIN, WORD_MAX, 1, 0, 1));
      directed.push_back(row(OP_GT, WORD_MIN, WORD_MAX, 1, 0, 0));
      directed.push_back(row(OP_LE, 7, 7, 1, 0, 1));
      directed.push_back(row(OP_GE, -1, 0, 1, 0, 0));
      directed.push_back(row(OP_EQ, WORD_MIN, WORD_MIN, 1, 0, 1));
      directed.push_back(row(OP_NE, 0, -1, 1, 0, 1));
      directed.push_back(row(OP_MIN, WORD_MIN, WORD_MAX, 1, WORD_MIN));
      directed.push_back(row(OP_MAX, WORD_MIN, WORD_MAX, 1, WORD_MAX));
      directed.push_back(row(OP_INC, WORD_MAX, 0, 1, WORD_MAX, 0, 1));
      directed.push_back(row(OP_DEC, WORD_MIN, -1, 1, WORD_MIN, 0, 1));
      directed.push_back(row(OP_TO_INT, -1, 0, 1, -1));
      directed.push_back(row(OP_FROM_INT, WORD_MIN, 0, 1, WORD_MIN, 0, 1));
      directed.push_back(row(OP_FROM_INT, -32'sh800000, 0, 1, WORD_MIN));
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) begin
         if (directed[i].typed) begin
            want = alu_predict(directed[i].op, directed[i].a, directed[i].b);
            if (want !== directed[i].res) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("table row %0d: expected %p predicted %p", i,
                           directed[i].res, want);
            end
         end
         send_operation(directed[i].op, directed[i].a, directed[i].b);
      end
      for (int n = 0; n < RANDOM_COUNT; n++) begin
         no_gaps = n >= 600 && n < 900;
         send_operation(op_type'($urandom_range(15)), random_operand(), random_operand());
      end
      req_ch.valid <= 1'b0;
      no_gaps = 1'b0;
      wait_cycles = 0;
      while (pending_results.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
